// ----- hdl/bch_systematic_encoder_defines.svh -----
// Assertion macros shared by the BCH encoder RTL.
`ifndef BCH_SYSTEMATIC_ENCODER_DEFINES_SVH
`define BCH_SYSTEMATIC_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCHSE_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCHSE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bchse_pkg.sv -----
// Package with the generator tables, code selection and shared types of the BCH encoder.
package bchse_pkg;

  // Width of one message or parity byte.
  localparam int DATA_W = 8;
  // Width of a byte count; holds up to 24 parity bytes.
  localparam int NB_W = 5;

  // Parity lengths of the four generators.
  localparam int R_T12   = 192;
  localparam int R_T10   = 160;
  localparam int R_T8    = 128;
  localparam int R_SHORT = 168;

  typedef enum logic [1:0] {
    CODE_T12   = 2'd0,
    CODE_T10   = 2'd1,
    CODE_T8    = 2'd2,
    CODE_SHORT = 2'd3
  } code_t;

  typedef enum logic {
    ST_DATA,
    ST_PARITY
  } state_t;

  // Control shared by every cell of the remainder chain.
  typedef struct packed {
    logic              load;   // a message byte is clocked in
    logic              shift;  // parity readout moves bytes toward cell 0
    logic              clear;  // last parity byte leaves, wipe the chain
    code_t             code;
    logic [NB_W-1:0]   nb;     // parity bytes of the selected code
    logic [DATA_W-1:0] fb;     // feedback bit per step, index 0 is the first step
  } cell_ctl_t;

  // Generator coefficients, index is the degree, the top index is the leading one.
  localparam logic [0:R_T12] POLY_T12 = {
    32'b11100111_10101010_01000000_01100110,
    32'b11101111_10100001_11100010_11000000,
    32'b10010001_00010000_10101100_00111011,
    32'b00011011_00110100_11110011_00001010,
    32'b00111000_10001010_00111010_00100001,
    32'b11000001_01110000_01100100_01110010,
    1'b1};

  localparam logic [0:R_T10] POLY_T10 = {
    32'b10001001_10100110_11011101_00011101,
    32'b10000000_11000100_10001011_11110111,
    32'b11000000_11101010_00011110_01010110,
    32'b11111000_11001100_01010100_00111111,
    32'b10110111_00110000_10101000_00000110,
    1'b1};

  localparam logic [0:R_T8] POLY_T8 = {
    32'b11010100_01100110_10011111_00100000,
    32'b10101110_10110110_00111111_10011000,
    32'b10111101_11101001_11100100_10001110,
    32'b11111010_10100100_11100000_00111000,
    1'b1};

  localparam logic [0:R_SHORT] POLY_SHORT = {
    32'b10100101_10100000_10011000_10001011,
    32'b11101011_11100111_11110001_01001010,
    32'b10010110_00001001_11000101_11000100,
    32'b10110011_01000110_01001101_10010110,
    32'b00011001_01010111_11011011_01000110,
    8'b00000010,
    1'b1};

  // Parity length in bits of a code.
  function automatic int r_of(code_t c);
    int r;
    case (c)
      CODE_T12: r = R_T12;
      CODE_T10: r = R_T10;
      CODE_T8:  r = R_T8;
      default:  r = R_SHORT;
    endcase
    return r;
  endfunction

  // Code actually used: a generator wider than the remainder falls back to t=8.
  function automatic code_t eff_code(code_t c, int max_bits);
    code_t e;
    e = c;
    if (r_of(c) > max_bits) begin
      e = CODE_T8;
    end
    return e;
  endfunction

  // Coefficient of degree d below the leading term, zero outside 0..r-1.
  function automatic logic tap_of(code_t c, int d);
    logic t;
    t = 1'b0;
    if (d >= 0 && d < r_of(c)) begin
      case (c)
        CODE_T12: t = POLY_T12[d];
        CODE_T10: t = POLY_T10[d];
        CODE_T8:  t = POLY_T8[d];
        default:  t = POLY_SHORT[d];
      endcase
    end
    return t;
  endfunction

endpackage

// ----- hdl/bchse_in_if.sv -----
// Input channel carrying message bytes.
interface bchse_in_if;
  import bchse_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hdl/bchse_out_if.sv -----
// Result channel carrying passed-through and parity bytes.
interface bchse_out_if;
  import bchse_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              is_parity;
  logic              end_of_codeword;

  modport source (output valid, output out_byte, output is_parity, output end_of_codeword,
                  input ready);
  modport sink (input valid, input out_byte, input is_parity, input end_of_codeword,
                output ready);
endinterface

// ----- hdl/bchse_cfg_if.sv -----
// Configuration write channel carrying the mode register.
interface bchse_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;

  modport source (output valid, output mode, input ready);
  modport sink (input valid, input mode, output ready);
endinterface

// ----- hdl/bchse_fb.sv -----
// Feedback unit: the eight feedback bits of one byte step from the head cell.
module bchse_fb (
  input  bchse_pkg::code_t             code,
  input  logic [bchse_pkg::DATA_W-1:0] data,
  input  logic [bchse_pkg::DATA_W-1:0] head,
  output logic [bchse_pkg::DATA_W-1:0] fb
);
  import bchse_pkg::*;

  // Each step sees the head bit corrected by the taps of the earlier feedbacks.
  // The feedback of step k lands its tap of degree r-b+k on the head at step b.
  always_comb begin
    logic acc;
    fb = '0;
    for (int b = 0; b < DATA_W; b++) begin
      acc = data[DATA_W-1-b] ^ head[DATA_W-1-b];
      for (int k = 0; k < b; k++) begin
        acc = acc ^ (fb[k] & tap_of(code, r_of(code) - b + k));
      end
      fb[b] = acc;
    end
  end
endmodule

// ----- hdl/bchse_cell.sv -----
// One byte cell of the remainder chain.
module bchse_cell #(
  parameter int Q = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bchse_pkg::cell_ctl_t         ctl,
  input  logic [bchse_pkg::DATA_W-1:0] nbr,
  output logic [bchse_pkg::DATA_W-1:0] byte_q
);
  import bchse_pkg::*;

  logic [DATA_W-1:0] byte_r;
  logic [DATA_W-1:0] byte_nxt;
  logic [DATA_W-1:0] contrib;
  logic              active;
  logic              tail;

  assign active = NB_W'(Q) < ctl.nb;
  assign tail   = NB_W'(Q + 1) == ctl.nb;
  assign byte_q = byte_r;

  // Generator taps that land in this byte after a full byte step.
  always_comb begin
    logic acc;
    contrib = '0;
    for (int j = 0; j < DATA_W; j++) begin
      acc = 1'b0;
      for (int b = 0; b < DATA_W; b++) begin
        acc = acc ^ (ctl.fb[b] & tap_of(ctl.code, r_of(ctl.code) - DATA_W - DATA_W*Q - j + b));
      end
      contrib[DATA_W-1-j] = acc;
    end
  end

  // Clear beats shift; bytes beyond the selected code hold on a load.
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = '0;
    end else if (ctl.shift) begin
      byte_nxt = nbr;
    end else if (ctl.load && active) begin
      byte_nxt = (tail ? '0 : nbr) ^ contrib;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end
endmodule

// ----- hdl/bch_systematic_encoder.sv -----
// Top level of the systematic BCH encoder for second generation satellite frames.
//
//   Channel  Dir  Payload                                   Transaction
//   in_if    in   data_byte[7:0], last_byte                 valid & ready
//   out_if   out  out_byte[7:0], is_parity, end_of_codeword valid & ready
//   cfg_if   in   mode[1:0]                                 valid & ready
//
// Unless out_if stalls, a message byte is taken every cycle, its pass-through copy appearing
// in the cycle after, and after the last byte 24, 20, 16 or 21 parity bytes follow, one per
// cycle, read out by shifting the cell chain toward cell 0; no input is taken in that burst.
// Reset is synchronous; it clears the remainder cells, the mode and the output valid flag.
// A stall on out_if holds the output register and stalls in_if in the same cycle.
module bch_systematic_encoder #(
  parameter int MAX_PARITY_BITS = 192
) (
  input  logic              clk,
  input  logic              rst_n,
  bchse_in_if.sink          in_if,
  bchse_out_if.source       out_if,
  bchse_cfg_if.sink         cfg_if
);
  import bchse_pkg::*;
  `include "bch_systematic_encoder_defines.svh"

  localparam int NCELL = (MAX_PARITY_BITS + DATA_W - 1) / DATA_W;

  // Mode register.
  logic [1:0] mode_r;
  logic [1:0] mode_nxt;

  assign cfg_if.ready = 1'b1;
  assign mode_nxt     = (cfg_if.valid && cfg_if.ready) ? cfg_if.mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Code selection and its parity byte count.
  code_t            code;
  logic [NB_W-1:0]  nb_bytes;

  assign code     = eff_code(code_t'(mode_r), MAX_PARITY_BITS);
  assign nb_bytes = NB_W'(r_of(code) / DATA_W);

  // Sequencer state and parity counter.
  state_t           state_r;
  state_t           state_nxt;
  logic [NB_W-1:0]  par_cnt_r;
  logic [NB_W-1:0]  par_cnt_nxt;
  logic             out_free;
  logic             accept;
  logic             emit;
  logic             last_emit;

  assign out_free = !out_if.valid || out_if.ready;
  assign accept   = in_if.valid && in_if.ready;

  always_comb begin
    state_nxt   = state_r;
    par_cnt_nxt = par_cnt_r;
    in_if.ready = 1'b0;
    emit        = 1'b0;
    last_emit   = 1'b0;
    case (state_r)
      ST_DATA: begin
        in_if.ready = out_free;
        if (in_if.valid && out_free && in_if.last_byte) begin
          state_nxt   = ST_PARITY;
          par_cnt_nxt = nb_bytes;
        end
      end
      ST_PARITY: begin
        emit      = out_free;
        last_emit = out_free && (par_cnt_r == NB_W'(1));
        if (out_free) begin
          par_cnt_nxt = par_cnt_r - NB_W'(1);
          if (par_cnt_r == NB_W'(1)) begin
            state_nxt = ST_DATA;
          end
        end
      end
      default: begin
        state_nxt = ST_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_DATA;
      par_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      par_cnt_r <= par_cnt_nxt;
    end
  end

  // Remainder chain: cell 0 holds the highest-degree byte.
  logic [DATA_W-1:0]       rem_byte [NCELL];
  logic [NCELL*DATA_W-1:0] rem_flat;
  logic [DATA_W-1:0]       fb;
  cell_ctl_t               ctl;

  bchse_fb u_fb (
    .code (code),
    .data (in_if.data_byte),
    .head (rem_byte[0]),
    .fb   (fb)
  );

  assign ctl.load  = accept;
  assign ctl.shift = emit;
  assign ctl.clear = last_emit;
  assign ctl.code  = code;
  assign ctl.nb    = nb_bytes;
  assign ctl.fb    = fb;

  for (genvar q = 0; q < NCELL; q++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (q + 1 < NCELL) begin : g_mid
      assign nbr = rem_byte[q+1];
    end else begin : g_end
      assign nbr = '0;
    end
    bchse_cell #(.Q(q)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .nbr    (nbr),
      .byte_q (rem_byte[q])
    );
    assign rem_flat[(NCELL-q)*DATA_W-1 -: DATA_W] = rem_byte[q];
  end

  // Output register: pass-through byte on a transaction, head cell during readout.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_byte_r;
  logic [DATA_W-1:0] out_byte_nxt;
  logic              is_parity_r;
  logic              is_parity_nxt;
  logic              eoc_r;
  logic              eoc_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_byte_nxt  = out_byte_r;
    is_parity_nxt = is_parity_r;
    eoc_nxt       = eoc_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = in_if.data_byte;
      is_parity_nxt = 1'b0;
      eoc_nxt       = 1'b0;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rem_byte[0];
      is_parity_nxt = 1'b1;
      eoc_nxt       = last_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    is_parity_r <= is_parity_nxt;
    eoc_r       <= eoc_nxt;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.out_byte        = out_byte_r;
  assign out_if.is_parity       = is_parity_r;
  assign out_if.end_of_codeword = eoc_r;

  // Checks on the sequencer and the remainder chain.
  `BCHSE_ASSERT_NEXT(a_cnt_load, clk, rst_n, accept && in_if.last_byte, par_cnt_r == $past(nb_bytes), "parity count not loaded with the code length")
  `BCHSE_ASSERT_NEXT(a_clear, clk, rst_n, last_emit, rem_flat == '0, "remainder not cleared after the last parity byte")
  `BCHSE_ASSERT_NOW(a_cnt_live, clk, rst_n, state_r == ST_PARITY, par_cnt_r != '0, "parity readout with an empty count")
endmodule

// ----- bench/bch_systematic_encoder_tb.sv -----
// Self-checking testbench for the BCH encoder: message bytes in, pass-through and parity bytes checked.
module bch_systematic_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bchse_pkg::*;

  localparam int MAX_BITS = 192;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 180;

  // Generator coefficients below the leading term, index is the degree.
  localparam logic [0:191] TAPS_T12 = {
    32'b11100111_10101010_01000000_01100110,
    32'b11101111_10100001_11100010_11000000,
    32'b10010001_00010000_10101100_00111011,
    32'b00011011_00110100_11110011_00001010,
    32'b00111000_10001010_00111010_00100001,
    32'b11000001_01110000_01100100_01110010};

  localparam logic [0:159] TAPS_T10 = {
    32'b10001001_10100110_11011101_00011101,
    32'b10000000_11000100_10001011_11110111,
    32'b11000000_11101010_00011110_01010110,
    32'b11111000_11001100_01010100_00111111,
    32'b10110111_00110000_10101000_00000110};

  localparam logic [0:127] TAPS_T8 = {
    32'b11010100_01100110_10011111_00100000,
    32'b10101110_10110110_00111111_10011000,
    32'b10111101_11101001_11100100_10001110,
    32'b11111010_10100100_11100000_00111000};

  localparam logic [0:167] TAPS_SHORT = {
    32'b10100101_10100000_10011000_10001011,
    32'b11101011_11100111_11110001_01001010,
    32'b10010110_00001001_11000101_11000100,
    32'b10110011_01000110_01001101_10010110,
    32'b00011001_01010111_11011011_01000110,
    8'b00000010};

  typedef struct packed {
    logic [7:0] value;
    logic       parity;
    logic       eoc;
  } coded_byte_t;

  // Tracks the running remainder and holds the bytes the encoder still owes.
  class parity_tracker;
    logic [0:191] rem;
    code_t        mode;
    coded_byte_t  expected_bytes[$];
    int           errors;

    function new();
      rem = '0;
      mode = CODE_T12;
      errors = 0;
    endfunction

    function void set_mode(code_t m);
      mode = m;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic tap(code_t c, int d);
      logic t;
      case (c)
        CODE_T12: t = TAPS_T12[d];
        CODE_T10: t = TAPS_T10[d];
        CODE_T8:  t = TAPS_T8[d];
        default:  t = TAPS_SHORT[d];
      endcase
      return t;
    endfunction

    // Clock one message byte into the remainder and queue what it produces.
    function void note_message_byte(logic [7:0] data, logic last);
      code_t       c;
      int          r;
      int          b;
      int          k;
      int          d;
      int          q;
      logic        fb;
      coded_byte_t beat;
      c = mode;
      case (c)
        CODE_T12: r = 192;
        CODE_T10: r = 160;
        CODE_T8:  r = 128;
        default:  r = 168;
      endcase
      // A generator wider than the remainder storage falls back to t=8.
      if (r > MAX_BITS) begin
        c = CODE_T8;
        r = 128;
      end
      // Bits above the current r stay untouched, which matters after a mode change.
      for (b = 7; b >= 0; b--) begin
        fb = data[b] ^ rem[0];
        for (k = 0; k < r - 1; k++) begin
          rem[k] = rem[k + 1];
        end
        rem[r - 1] = 1'b0;
        if (fb) begin
          for (d = 0; d < r; d++) begin
            if (tap(c, d)) begin
              rem[r - 1 - d] = ~rem[r - 1 - d];
            end
          end
        end
      end
      beat.value = data;
      beat.parity = 1'b0;
      beat.eoc = 1'b0;
      expected_bytes.push_back(beat);
      // Parity burst after the final message byte, highest coefficient first.
      if (last) begin
        for (q = 0; q < r / 8; q++) begin
          beat.value = rem[8 * q +: 8];
          beat.parity = 1'b1;
          beat.eoc = (q == r / 8 - 1);
          expected_bytes.push_back(beat);
        end
        rem = '0;
      end
    endfunction

    // Compare one output transaction with the oldest owed byte.
    function void check_output_byte(logic [7:0] value, logic parity, logic eoc);
      coded_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte %02h parity %0b end %0b",
                 $time, value, parity, eoc);
      end else begin
        want = expected_bytes.pop_front();
        if (want.value !== value) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time, want.value, value);
        end
        if (want.parity !== parity) begin
          errors++;
          $display("%0t: is_parity expected %0b actual %0b", $time, want.parity, parity);
        end
        if (want.eoc !== eoc) begin
          errors++;
          $display("%0t: end_of_codeword expected %0b actual %0b", $time, want.eoc, eoc);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle = 1'b0;
  int   cycles = 0;

  parity_tracker tracker = new();

  bchse_in_if  in_ch();
  bchse_out_if out_ch();
  bchse_cfg_if cfg_ch();

  bch_systematic_encoder #(
    .MAX_PARITY_BITS(MAX_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bch_systematic_encoder_tb NOT OK");
      $finish;
    end
  end

  // Check every output transaction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_output_byte(out_ch.out_byte, out_ch.is_parity, out_ch.end_of_codeword);
    end
  end

  // Output side: stall for a random gap before each transaction.
  initial begin : out_side
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Offer one message byte after a random gap and wait for the transaction.
  task automatic send_message_byte(logic [7:0] data, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_message_byte(data, last);
  endtask

  // Stop sending and wait until every owed byte has come out.
  task automatic wait_all_bytes_out();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the mode register; only called once every owed byte has come out.
  task automatic write_mode(code_t m);
    cfg_ch.valid <= 1'b1;
    cfg_ch.mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tracker.set_mode(m);
  endtask

  initial begin
    int    sent;
    int    phase;
    int    blocks;
    int    len;
    int    i;
    int    j;
    bit    complete;
    logic  last;
    code_t m;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    out_ch.ready <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.mode <= CODE_T12;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset mode is t=12: all-zero and all-ones single-byte messages.
    send_message_byte(8'h00, 1'b1);
    send_message_byte(8'hFF, 1'b1);

    // Each generator once.
    wait_all_bytes_out();
    write_mode(CODE_T10);
    send_message_byte(8'h80, 1'b0);
    send_message_byte(8'h01, 1'b1);
    wait_all_bytes_out();
    write_mode(CODE_T8);
    send_message_byte(8'hA5, 1'b0);
    send_message_byte(8'h5A, 1'b0);
    send_message_byte(8'hFF, 1'b1);
    wait_all_bytes_out();
    write_mode(CODE_SHORT);
    send_message_byte(8'h00, 1'b0);
    send_message_byte(8'hFF, 1'b1);

    // Mode narrowed inside a codeword; the upper remainder bytes linger until the clear.
    wait_all_bytes_out();
    write_mode(CODE_T12);
    send_message_byte(8'h3C, 1'b0);
    send_message_byte(8'hC3, 1'b0);
    wait_all_bytes_out();
    write_mode(CODE_SHORT);
    send_message_byte(8'h81, 1'b1);
    wait_all_bytes_out();
    write_mode(CODE_T12);
    send_message_byte(8'h7E, 1'b1);

    // Mode widened inside a codeword.
    wait_all_bytes_out();
    write_mode(CODE_T8);
    send_message_byte(8'h96, 1'b0);
    wait_all_bytes_out();
    write_mode(CODE_T12);
    send_message_byte(8'h69, 1'b1);

    // Random codewords in phases, each under a fresh mode; some phases end mid-codeword.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      wait_all_bytes_out();
      case (phase)
        0:       m = CODE_SHORT;
        1:       m = CODE_T12;
        default: m = code_t'($urandom_range(0, 3));
      endcase
      write_mode(m);
      no_idle = ($urandom_range(0, 3) == 0);
      blocks = $urandom_range(1, 3);
      for (j = 0; j < blocks; j++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
        complete = !(j == blocks - 1 && $urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++) begin
          // Occasionally a stray last flag splits the codeword early.
          last = (complete && i == len - 1) || ($urandom_range(0, 19) == 0);
          send_message_byte(8'($urandom_range(0, 255)), last);
        end
        sent += len;
      end
      phase++;
    end

    wait_all_bytes_out();
    repeat (16) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("bch_systematic_encoder_tb OK");
    end else begin
      $display("bch_systematic_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
